/* design/quoted_literal_unescaper_macros.svh */
// Assertion macros shared by the quoted literal unescaper checkers.
// No dependencies; expects clk and rst to exist where a macro is used.
`ifndef QUOTED_LITERAL_UNESCAPER_MACROS_SVH
`define QUOTED_LITERAL_UNESCAPER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define QLU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define QLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/qlu_pkg.sv */
// Shared types, character codes and helper functions for the unescaper.
// No dependencies; used by qlu_core and quoted_literal_unescaper.
`default_nettype none

package qlu_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       literal_done;
    logic       single_char_kind;
    logic       unterminated;
    logic       run_last;
  } res_t;

  // All words caused by one source byte, lowest slot delivered first.
  typedef struct packed {
    res_t [MAX_RES-1:0] items;
    logic [2:0]         cnt;
  } grp_t;

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

  // Returns {valid, digit value}.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic res_t char_res(input logic [7:0] ch);
    res_t r;
    r = '0;
    r.out_char   = ch;
    r.char_valid = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/qlu_core.sv */
// Literal decoding state and the single-pass decode of one source byte.
// Depends on qlu_pkg; produces the group of words that the byte causes.
`default_nettype none

module qlu_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    src_byte,
  input  wire logic          source_end,
  output qlu_pkg::grp_t      grp
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_BODY, PH_ESC, PH_OCT, PH_HEX1, PH_HEX2
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] delimiter, delimiter_next;
  logic [7:0] octal_value, octal_value_next;
  logic [1:0] octal_count, octal_count_next;
  logic [1:0] octal_limit, octal_limit_next;
  logic [7:0] first_hex_byte, first_hex_byte_next;
  logic [1:0] decoded_count, decoded_count_next;

  logic [7:0] pre_ch [3];
  logic [1:0] pre_n;
  logic       do_body;
  logic [2:0] n;
  logic [4:0] hv_cur, hv_first;
  logic [7:0] oct_shift;
  logic [1:0] oct_cnt_inc;

  function automatic logic [1:0] sat_inc(input logic [1:0] v);
    return (v == 2'd2) ? v : v + 2'd1;
  endfunction

  assign hv_cur      = qlu_pkg::hex_val(src_byte);
  assign hv_first    = qlu_pkg::hex_val(first_hex_byte);
  assign oct_shift   = {octal_value[4:0], src_byte[2:0]};
  assign oct_cnt_inc = octal_count + 2'd1;

  always_comb begin
    phase_next          = phase;
    delimiter_next      = delimiter;
    octal_value_next    = octal_value;
    octal_count_next    = octal_count;
    octal_limit_next    = octal_limit;
    first_hex_byte_next = first_hex_byte;
    decoded_count_next  = decoded_count;
    pre_ch[0] = 8'h00;
    pre_ch[1] = 8'h00;
    pre_ch[2] = 8'h00;
    pre_n     = 2'd0;
    do_body   = 1'b0;
    grp       = '0;
    n         = 3'd0;

    if (source_end) begin
      if (phase != PH_IDLE) begin
        grp.items[0].unterminated = 1'b1;
        n = 3'd1;
      end
      phase_next         = PH_IDLE;
      decoded_count_next = 2'd0;
      octal_value_next   = 8'h00;
      octal_count_next   = 2'd0;
    end else begin
      case (phase)
        PH_IDLE: begin
          delimiter_next      = src_byte;
          decoded_count_next  = 2'd0;
          octal_value_next    = 8'h00;
          octal_count_next    = 2'd0;
          octal_limit_next    = 2'd0;
          first_hex_byte_next = 8'h00;
          phase_next          = PH_BODY;
        end
        PH_BODY: begin
          do_body = 1'b1;
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          if (src_byte inside {qlu_pkg::CH_DQUOTE, qlu_pkg::CH_SQUOTE,
                               qlu_pkg::CH_BSLASH}) begin
            pre_ch[0] = src_byte;
            pre_n     = 2'd1;
          end else if (src_byte == qlu_pkg::CH_N) begin
            pre_ch[0] = qlu_pkg::CH_LF;
            pre_n     = 2'd1;
          end else if (src_byte == qlu_pkg::CH_R) begin
            pre_ch[0] = qlu_pkg::CH_CR;
            pre_n     = 2'd1;
          end else if (src_byte == qlu_pkg::CH_T) begin
            pre_ch[0] = qlu_pkg::CH_TAB;
            pre_n     = 2'd1;
          end else if (qlu_pkg::is_octal(src_byte)) begin
            octal_value_next = {5'd0, src_byte[2:0]};
            octal_count_next = 2'd1;
            octal_limit_next = (src_byte <= qlu_pkg::CH_THREE) ? 2'd3 : 2'd2;
            phase_next       = PH_OCT;
          end else if (src_byte == qlu_pkg::CH_X) begin
            phase_next = PH_HEX1;
          end else begin
            // Unknown escape: a literal backslash, then the byte as body.
            pre_ch[0] = qlu_pkg::CH_BSLASH;
            pre_n     = 2'd1;
            do_body   = 1'b1;
          end
        end
        PH_OCT: begin
          if (qlu_pkg::is_octal(src_byte)) begin
            octal_value_next = oct_shift;
            octal_count_next = oct_cnt_inc;
            if (oct_cnt_inc >= octal_limit) begin
              pre_ch[0]  = oct_shift;
              pre_n      = 2'd1;
              phase_next = PH_BODY;
            end
          end else begin
            pre_ch[0]  = octal_value;
            pre_n      = 2'd1;
            phase_next = PH_BODY;
            do_body    = 1'b1;
          end
        end
        PH_HEX1: begin
          if (hv_cur[4]) begin
            first_hex_byte_next = src_byte;
            phase_next          = PH_HEX2;
          end else begin
            pre_ch[0]  = qlu_pkg::CH_BSLASH;
            pre_ch[1]  = qlu_pkg::CH_X;
            pre_n      = 2'd2;
            phase_next = PH_BODY;
            do_body    = 1'b1;
          end
        end
        PH_HEX2: begin
          phase_next = PH_BODY;
          if (hv_cur[4]) begin
            pre_ch[0] = {(hv_first[4] ? hv_first[3:0] : 4'h0), hv_cur[3:0]};
            pre_n     = 2'd1;
          end else begin
            pre_ch[0] = qlu_pkg::CH_BSLASH;
            pre_ch[1] = qlu_pkg::CH_X;
            pre_ch[2] = first_hex_byte;
            pre_n     = 2'd3;
            do_body   = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase

      for (int i = 0; i < 3; i++) begin
        if (2'(i) < pre_n) begin
          grp.items[i]       = qlu_pkg::char_res(pre_ch[i]);
          decoded_count_next = sat_inc(decoded_count_next);
        end
      end
      n = {1'b0, pre_n};

      if (do_body) begin
        if (src_byte == qlu_pkg::CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (src_byte == delimiter) begin
          grp.items[n[1:0]].literal_done     = 1'b1;
          grp.items[n[1:0]].single_char_kind = (decoded_count_next == 2'd1);
          n                  = n + 3'd1;
          phase_next         = PH_IDLE;
          decoded_count_next = 2'd0;
        end else begin
          grp.items[n[1:0]]  = qlu_pkg::char_res(src_byte);
          n                  = n + 3'd1;
          decoded_count_next = sat_inc(decoded_count_next);
        end
      end
    end

    if (n != 3'd0) begin
      grp.items[n[1:0] - 2'd1].run_last = 1'b1;
    end
    grp.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      delimiter      <= 8'h00;
      octal_value    <= 8'h00;
      octal_count    <= 2'd0;
      octal_limit    <= 2'd0;
      first_hex_byte <= 8'h00;
      decoded_count  <= 2'd0;
    end else if (accept) begin
      phase          <= phase_next;
      delimiter      <= delimiter_next;
      octal_value    <= octal_value_next;
      octal_count    <= octal_count_next;
      octal_limit    <= octal_limit_next;
      first_hex_byte <= first_hex_byte_next;
      decoded_count  <= decoded_count_next;
    end
  end

endmodule

`default_nettype wire

/* design/quoted_literal_unescaper.sv */
// Channel  | Dir | tdata            | tuser (low bit up)                       | tlast
// s_axis   | in  | src_byte         | -                                        | source_end
// m_axis   | out | out_char         | char_valid, literal_done, kind, unterm.  | run_last
//
// A source byte that causes at most one word is taken every cycle unless the master
// side stalls. A byte that causes k words (up to four) holds the slave side until all
// k are sent, one word per cycle while the master side is not stalled. The decode is
// one combinational pass into a group register, followed by a one-word output register.
// Reset is synchronous on rst; after it any byte is taken as the opening delimiter.
// Either side may stall freely; the group register and output register part them.
// Depends on qlu_pkg and qlu_core.
`default_nettype none

module quoted_literal_unescaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] src_byte
  input  wire logic       s_tlast,   // source_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic [3:0]      m_tuser,   // [0] char_valid [1] literal_done
                                     // [2] single_char_kind [3] unterminated
  output logic            m_tlast    // run_last
);

  qlu_pkg::grp_t grp_new;
  qlu_pkg::grp_t grp_q;
  qlu_pkg::res_t out_q;
  logic          move;
  logic          accept;

  assign move     = (grp_q.cnt != 3'd0) && (!m_tvalid || m_tready);
  assign s_tready = (grp_q.cnt == 3'd0) || ((grp_q.cnt == 3'd1) && move);
  assign accept   = s_tvalid && s_tready;

  qlu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .src_byte   (s_tdata),
    .source_end (s_tlast),
    .grp        (grp_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      grp_q.cnt <= 3'd0;
    end else begin
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        grp_q.cnt <= grp_new.cnt;
      end else if (move) begin
        grp_q.cnt <= grp_q.cnt - 3'd1;
      end
    end
    // Word payloads; the group drains from its lowest slot.
    if (move) begin
      out_q <= grp_q.items[0];
    end
    if (accept) begin
      grp_q.items <= grp_new.items;
    end else if (move) begin
      grp_q.items <= {qlu_pkg::res_t'('0), grp_q.items[qlu_pkg::MAX_RES-1:1]};
    end
  end

  assign m_tdata = out_q.out_char;
  assign m_tuser = {out_q.unterminated, out_q.single_char_kind,
                    out_q.literal_done, out_q.char_valid};
  assign m_tlast = out_q.run_last;

endmodule

`default_nettype wire

/* design/qlu_checker.sv */
// Port-level checks for quoted_literal_unescaper, attached by bind.
// Depends on quoted_literal_unescaper_macros.svh.
`default_nettype none
`include "quoted_literal_unescaper_macros.svh"

module qlu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [3:0] m_tuser,
  input wire logic       m_tlast
);

  `QLU_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "word dropped while stalled")
  `QLU_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled word changed")
  `QLU_ASSERT_NOW(a_zero_char, m_tvalid && !m_tuser[0], m_tdata == 8'h00, "status word carries a byte")
  `QLU_ASSERT_NOW(a_kind_done, m_tvalid && m_tuser[2], m_tuser[1], "char kind outside a done word")
  `QLU_ASSERT_NOW(a_end_last, m_tvalid && (m_tuser[1] || m_tuser[3]), m_tlast, "end word is not last")

endmodule

bind quoted_literal_unescaper qlu_checker u_qlu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
